// ===== rtl/core/pss_pkg.sv =====
// Package for the positional sequence store.
// Holds the operation and status codes and the stream word widths.
// No dependencies.
`default_nettype none

package pss_pkg;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 48;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_SORTED = 3'd1;
    localparam logic [2:0] OP_ERASE  = 3'd2;
    localparam logic [2:0] OP_REMOVE = 3'd3;
    localparam logic [2:0] OP_GET    = 3'd4;
    localparam logic [2:0] OP_SET    = 3'd5;
    localparam logic [2:0] OP_FIND   = 3'd6;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BADPOS   = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

`default_nettype wire

// ===== rtl/core/positional_sequence_store.sv =====
// Positional sequence store: ordered list with positional and sorted insert.
// Depends on pss_pkg and pss_ram.
//
// Channel  Dir  Accepted when            Payload
// s        in   i_s_tvalid & o_s_tready  opcode, position, value
// m        out  o_m_tvalid & i_m_tready  status, index, read_value, item_count
//
// One transaction at a time; entries are walked one per cycle through a single
// RAM port pair (registered read). Set writes directly, get reads one entry,
// find and remove walk the list from the front, insert shifts down from the end
// to position P, erase shifts up from P+1, and sorted insert searches, then
// shifts. Reset clears the state, count and valid flags only, not the RAM; no
// clearing pass. A waiting result stalls the next completion, not the next accept.
`default_nettype none

module positional_sequence_store #(
    parameter int CAPACITY    = 32,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_s_tvalid,
    output logic                                  o_s_tready,
    // [2:0] opcode, [8:3] position, [40:9] value, [47:41] zero
    input  wire logic [pss_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    output logic                                  o_m_tvalid,
    input  wire logic                             i_m_tready,
    // [1:0] status, [7:2] index, [39:8] read_value, [45:40] item_count, [47:46] zero
    output logic      [pss_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = (CW > 6) ? CW : 6;
    localparam int VW = VALUE_WIDTH;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ASC,
        S_DESC,
        S_PUT,
        S_DONE
    } t_state;

    t_state          r_state, n_state;
    logic [2:0]      r_op, n_op;
    logic [CW-1:0]   r_pos, n_pos;
    logic [VW-1:0]   r_val, n_val;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_ptr, n_ptr;
    logic            r_iss, n_iss;
    logic            r_rv, n_rv;
    logic [CW-1:0]   r_ridx, n_ridx;
    logic [CW-1:0]   r_wptr, n_wptr;
    logic [CW-1:0]   r_hits, n_hits;
    logic [1:0]      r_st, n_st;
    logic [CW-1:0]   r_ix, n_ix;
    logic [VW-1:0]   r_rd, n_rd;
    logic            r_ovalid, n_ovalid;
    logic [1:0]      r_ostat, n_ostat;
    logic [5:0]      r_oidx, n_oidx;
    logic [31:0]     r_ordata, n_ordata;
    logic [5:0]      r_ocount, n_ocount;

    logic            in_fire;
    logic [2:0]      in_op;
    logic [5:0]      in_pos;
    logic [VW-1:0]   in_val;
    logic [PW-1:0]   pos_ext, cnt_ext, ix_ext, cnt_out_ext;
    logic [CW-1:0]   pos_c, cnt_m1, cap_c, ridx_m1, ridx_p1;
    logic            full, last, hit;
    logic            asc_iss, desc_iss;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [VW-1:0]   ram_wdata, ram_rdata;

    pss_ram #(
        .WIDTH (VW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_s_tready = (r_state == S_IDLE);
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign in_op      = i_s_tdata[2:0];
    assign in_pos     = i_s_tdata[8:3];
    assign in_val     = VW'(i_s_tdata[40:9]);

    assign pos_ext = PW'(in_pos);
    assign cnt_ext = PW'(r_count);
    assign pos_c   = CW'(in_pos);
    assign cap_c   = CW'(CAPACITY);
    assign cnt_m1  = r_count - CW'(1);
    assign ridx_m1 = r_ridx - CW'(1);
    assign ridx_p1 = r_ridx + CW'(1);
    assign full    = (r_count == cap_c);
    assign last    = (r_ridx == cnt_m1);
    assign hit     = (ram_rdata == r_val);

    assign asc_iss   = (r_state == S_ASC) && r_iss && (r_ptr < r_count);
    assign desc_iss  = (r_state == S_DESC) && r_iss;
    assign ram_re    = asc_iss || desc_iss;
    assign ram_raddr = r_ptr[AW-1:0];

    assign ix_ext      = PW'(r_ix);
    assign cnt_out_ext = PW'(r_count);

    always_comb begin
        n_state   = r_state;
        n_op      = r_op;
        n_pos     = r_pos;
        n_val     = r_val;
        n_count   = r_count;
        n_ptr     = r_ptr;
        n_iss     = r_iss;
        n_rv      = ram_re;
        n_ridx    = r_ptr;
        n_wptr    = r_wptr;
        n_hits    = r_hits;
        n_st      = r_st;
        n_ix      = r_ix;
        n_rd      = r_rd;
        n_ovalid  = r_ovalid && !i_m_tready;
        n_ostat   = r_ostat;
        n_oidx    = r_oidx;
        n_ordata  = r_ordata;
        n_ocount  = r_ocount;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = '0;

        if (asc_iss) begin
            n_ptr = r_ptr + CW'(1);
        end
        if (desc_iss) begin
            if (r_ptr == r_pos) begin
                n_iss = 1'b0;
            end else begin
                n_ptr = r_ptr - CW'(1);
            end
        end

        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    n_op   = in_op;
                    n_val  = in_val;
                    n_pos  = pos_c;
                    n_st   = pss_pkg::ST_OK;
                    n_ix   = '0;
                    n_rd   = '0;
                    n_iss  = 1'b1;
                    n_ptr  = '0;
                    n_wptr = '0;
                    n_hits = '0;
                    case (in_op)
                        pss_pkg::OP_INSERT: begin
                            if (pos_ext > cnt_ext) begin
                                n_st    = pss_pkg::ST_BADPOS;
                                n_state = S_DONE;
                            end else if (full) begin
                                n_st    = pss_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else if (pos_ext == cnt_ext) begin
                                n_state = S_PUT;
                            end else begin
                                n_ptr   = cnt_m1;
                                n_state = S_DESC;
                            end
                        end
                        pss_pkg::OP_SORTED: begin
                            if (full) begin
                                n_st    = pss_pkg::ST_FULL;
                                n_state = S_DONE;
                            end else if (r_count == '0) begin
                                n_pos   = '0;
                                n_state = S_PUT;
                            end else begin
                                n_state = S_ASC;
                            end
                        end
                        pss_pkg::OP_ERASE: begin
                            if (pos_ext >= cnt_ext) begin
                                n_st    = pss_pkg::ST_BADPOS;
                                n_state = S_DONE;
                            end else if (pos_ext == cnt_ext - PW'(1)) begin
                                n_count = cnt_m1;
                                n_ix    = pos_c;
                                n_state = S_DONE;
                            end else begin
                                n_ptr   = pos_c + CW'(1);
                                n_state = S_ASC;
                            end
                        end
                        pss_pkg::OP_REMOVE: begin
                            if (r_count == '0) begin
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ASC;
                            end
                        end
                        pss_pkg::OP_GET: begin
                            if (pos_ext >= cnt_ext) begin
                                n_st    = pss_pkg::ST_BADPOS;
                                n_state = S_DONE;
                            end else begin
                                n_ptr   = pos_c;
                                n_state = S_ASC;
                            end
                        end
                        pss_pkg::OP_SET: begin
                            if (pos_ext >= cnt_ext) begin
                                n_st = pss_pkg::ST_BADPOS;
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = pos_c[AW-1:0];
                                ram_wdata = in_val;
                                n_ix      = pos_c;
                            end
                            n_state = S_DONE;
                        end
                        pss_pkg::OP_FIND: begin
                            if (r_count == '0) begin
                                n_st    = pss_pkg::ST_NOTFOUND;
                                n_state = S_DONE;
                            end else begin
                                n_state = S_ASC;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_ASC: begin
                if (r_rv) begin
                    case (r_op)
                        pss_pkg::OP_SORTED: begin
                            if (r_val <= ram_rdata) begin
                                n_pos   = r_ridx;
                                n_ptr   = cnt_m1;
                                n_iss   = 1'b1;
                                n_rv    = 1'b0;
                                n_state = S_DESC;
                            end else if (last) begin
                                n_pos   = r_count;
                                n_rv    = 1'b0;
                                n_state = S_PUT;
                            end
                        end
                        pss_pkg::OP_FIND: begin
                            if (hit) begin
                                n_ix    = r_ridx;
                                n_state = S_DONE;
                            end else if (last) begin
                                n_st    = pss_pkg::ST_NOTFOUND;
                                n_state = S_DONE;
                            end
                        end
                        pss_pkg::OP_GET: begin
                            n_ix    = r_ridx;
                            n_rd    = ram_rdata;
                            n_state = S_DONE;
                        end
                        pss_pkg::OP_ERASE: begin
                            ram_we    = 1'b1;
                            ram_waddr = ridx_m1[AW-1:0];
                            ram_wdata = ram_rdata;
                            if (last) begin
                                n_count = cnt_m1;
                                n_ix    = r_pos;
                                n_state = S_DONE;
                            end
                        end
                        pss_pkg::OP_REMOVE: begin
                            if (hit) begin
                                n_hits = r_hits + CW'(1);
                            end else begin
                                ram_we    = 1'b1;
                                ram_waddr = r_wptr[AW-1:0];
                                ram_wdata = ram_rdata;
                                n_wptr    = r_wptr + CW'(1);
                            end
                            if (last) begin
                                n_count = n_wptr;
                                n_ix    = n_hits;
                                n_state = S_DONE;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end

            S_DESC: begin
                if (r_rv) begin
                    ram_we    = 1'b1;
                    ram_waddr = ridx_p1[AW-1:0];
                    ram_wdata = ram_rdata;
                    if (r_ridx == r_pos) begin
                        n_state = S_PUT;
                    end
                end
            end

            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos[AW-1:0];
                ram_wdata = r_val;
                n_count   = r_count + CW'(1);
                n_ix      = r_pos;
                n_state   = S_DONE;
            end

            S_DONE: begin
                if (!r_ovalid || i_m_tready) begin
                    n_ovalid = 1'b1;
                    n_ostat  = r_st;
                    n_oidx   = ix_ext[5:0];
                    n_ordata = 32'(r_rd);
                    n_ocount = cnt_out_ext[5:0];
                    n_state  = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_iss    <= 1'b0;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_iss    <= n_iss;
            r_rv     <= n_rv;
            r_ovalid <= n_ovalid;
            r_op     <= n_op;
            r_pos    <= n_pos;
            r_val    <= n_val;
            r_ptr    <= n_ptr;
            r_ridx   <= n_ridx;
            r_wptr   <= n_wptr;
            r_hits   <= n_hits;
            r_st     <= n_st;
            r_ix     <= n_ix;
            r_rd     <= n_rd;
            r_ostat  <= n_ostat;
            r_oidx   <= n_oidx;
            r_ordata <= n_ordata;
            r_ocount <= n_ocount;
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {2'b00, r_ocount, r_ordata, r_oidx, r_ostat};

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= cap_c)
        else $error("item count above capacity");

    a_idx_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && (r_ostat != pss_pkg::ST_OK)) |-> (r_oidx == 6'd0))
        else $error("non-zero index with error status");

    a_shift_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DESC) && r_rv) |-> ((r_ridx >= r_pos) && (r_ridx < r_count)))
        else $error("shift read outside insert span");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/pss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pss_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// Testbench for positional_sequence_store: directed and random list operations
// checked against an in-bench list model, with stalls on both streams.
// Depends on pss_pkg and the store RTL.

module tb;

    localparam int         LIST_CAP    = 32;
    localparam int         CYCLE_LIMIT = 400000;
    localparam int         SETTLE      = 80;
    localparam logic [2:0] OP_NONE     = 3'd7;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  index;
        logic [31:0] rd_value;
        logic [5:0]  count;
    } t_list_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    // [2:0] opcode, [8:3] position, [40:9] value, [47:41] zero
    logic [pss_pkg::IN_TDATA_W-1:0] i_s_tdata  = '0;
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    // [1:0] status, [7:2] index, [39:8] read_value, [45:40] item_count, [47:46] zero
    logic [pss_pkg::OUT_TDATA_W-1:0] o_m_tdata;

    logic [31:0]  list_mem [LIST_CAP];
    int           list_len;
    t_list_result expected_results [$];

    int errors      = 0;
    int results_in  = 0;
    int full_hits   = 0;
    int peak_len    = 0;
    int cycle_count = 0;
    int op_hits [8];

    int sink_hold  = 0;
    bit sink_quiet = 1'b1;

    positional_sequence_store dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #4 i_clk = ~i_clk;

    // list model, updated once per accepted transaction
    function automatic void shift_in(int at, logic [31:0] val);
        int i;
        for (i = list_len; i > at; i--) list_mem[i] = list_mem[i - 1];
        list_mem[at] = val;
        list_len++;
    endfunction

    function automatic t_list_result apply_list_op(logic [2:0] op, logic [5:0] pos,
                                                   logic [31:0] val);
        t_list_result r;
        int i;
        int w;
        int hits;
        r.status   = pss_pkg::ST_OK;
        r.index    = '0;
        r.rd_value = '0;
        case (op)
            pss_pkg::OP_INSERT: begin
                if (int'(pos) > list_len) begin
                    r.status = pss_pkg::ST_BADPOS;
                end else if (list_len >= LIST_CAP) begin
                    r.status = pss_pkg::ST_FULL;
                end else begin
                    shift_in(int'(pos), val);
                    r.index = pos;
                end
            end
            pss_pkg::OP_SORTED: begin
                if (list_len >= LIST_CAP) begin
                    r.status = pss_pkg::ST_FULL;
                end else begin
                    i = 0;
                    while (i < list_len && val > list_mem[i]) i++;
                    shift_in(i, val);
                    r.index = 6'(i);
                end
            end
            pss_pkg::OP_ERASE: begin
                if (int'(pos) >= list_len) begin
                    r.status = pss_pkg::ST_BADPOS;
                end else begin
                    for (i = int'(pos); i + 1 < list_len; i++) list_mem[i] = list_mem[i + 1];
                    list_len--;
                    r.index = pos;
                end
            end
            pss_pkg::OP_REMOVE: begin
                w    = 0;
                hits = 0;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == val) begin
                        hits++;
                    end else begin
                        list_mem[w] = list_mem[i];
                        w++;
                    end
                end
                list_len = w;
                r.index  = 6'(hits);
            end
            pss_pkg::OP_GET: begin
                if (int'(pos) >= list_len) begin
                    r.status = pss_pkg::ST_BADPOS;
                end else begin
                    r.rd_value = list_mem[pos[4:0]];
                    r.index    = pos;
                end
            end
            pss_pkg::OP_SET: begin
                if (int'(pos) >= list_len) begin
                    r.status = pss_pkg::ST_BADPOS;
                end else begin
                    list_mem[pos[4:0]] = val;
                    r.index            = pos;
                end
            end
            pss_pkg::OP_FIND: begin
                r.status = pss_pkg::ST_NOTFOUND;
                for (i = 0; i < list_len; i++) begin
                    if (list_mem[i] == val) begin
                        r.status = pss_pkg::ST_OK;
                        r.index  = 6'(i);
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        r.count = 6'(list_len);
        if (r.status == pss_pkg::ST_FULL) full_hits++;
        if (list_len > peak_len) peak_len = list_len;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        errors++;
        if (errors <= 40)
            $display("tb: mismatch on %s, got %0h want %0h (result %0d)",
                     what, got, want, results_in);
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) report_mismatch(what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_list_result want;
        if (o_m_tvalid === 1'b1 && i_m_tready) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result", o_m_tdata[31:0], '0);
            end else begin
                want = expected_results.pop_front();
                check_field("status", 32'(o_m_tdata[1:0]), 32'(want.status));
                check_field("index", 32'(o_m_tdata[7:2]), 32'(want.index));
                check_field("read_value", o_m_tdata[39:8], want.rd_value);
                check_field("item_count", 32'(o_m_tdata[45:40]), 32'(want.count));
            end
            results_in++;
        end
    end

    // receiver: always ready while quiet, else runs of ready and stall of random length, or a long hold
    initial begin : sink_pattern
        int hi_run;
        int lo_run;
        hi_run = 0;
        lo_run = 0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                i_m_tready <= 1'b0;
                sink_hold--;
            end else if (sink_quiet) begin
                i_m_tready <= 1'b1;
            end else begin
                if (hi_run == 0 && lo_run == 0) begin
                    hi_run = $urandom_range(16, 1);
                    lo_run = $urandom_range(6, 0);
                end
                if (hi_run > 0) begin
                    i_m_tready <= 1'b1;
                    hi_run--;
                end else begin
                    i_m_tready <= 1'b0;
                    lo_run--;
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("tb: failure");
        $finish;
    end

    task automatic push_op(logic [2:0] op, logic [5:0] pos, logic [31:0] val);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(pss_pkg::IN_TDATA_W - 41){1'b0}}, val, pos, op};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        expected_results.push_back(apply_list_op(op, pos, val));
        op_hits[op]++;
    endtask

    task automatic source_idle(int cycles);
        i_s_tvalid <= 1'b0;
        repeat (cycles) @(posedge i_clk);
    endtask

    task automatic wait_drain();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (expected_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic apply_reset();
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        list_len = 0;
    endtask

    task automatic test_empty_list();
        push_op(pss_pkg::OP_GET, 6'd0, 32'h0);
        push_op(pss_pkg::OP_ERASE, 6'd0, 32'h0);
        push_op(pss_pkg::OP_SET, 6'd0, 32'hffff_ffff);
        push_op(pss_pkg::OP_FIND, 6'd0, 32'h0);
        push_op(pss_pkg::OP_REMOVE, 6'd0, 32'h5);
        push_op(pss_pkg::OP_INSERT, 6'd1, 32'h1);
        push_op(OP_NONE, 6'd63, 32'hffff_ffff);
        wait_drain();
    endtask

    task automatic test_basic_ops();
        push_op(pss_pkg::OP_INSERT, 6'd0, 32'hffff_ffff);
        push_op(pss_pkg::OP_INSERT, 6'd1, 32'h0);
        push_op(pss_pkg::OP_SORTED, 6'd0, 32'h8000_0000);
        push_op(pss_pkg::OP_INSERT, 6'd63, 32'h1);
        push_op(pss_pkg::OP_SORTED, 6'd0, 32'h5);
        push_op(pss_pkg::OP_SORTED, 6'd0, 32'h5);
        push_op(pss_pkg::OP_GET, 6'd2, 32'h0);
        push_op(pss_pkg::OP_SET, 6'd1, 32'h1234_5678);
        push_op(pss_pkg::OP_FIND, 6'd0, 32'h1234_5678);
        push_op(pss_pkg::OP_FIND, 6'd0, 32'h7);
        push_op(pss_pkg::OP_REMOVE, 6'd0, 32'h5);
        push_op(pss_pkg::OP_REMOVE, 6'd0, 32'h6);
        push_op(OP_NONE, 6'd0, 32'h0);
        push_op(pss_pkg::OP_ERASE, 6'(list_len), 32'h0);
        push_op(pss_pkg::OP_ERASE, 6'd0, 32'h0);
        push_op(pss_pkg::OP_GET, 6'd63, 32'h0);
        wait_drain();
    endtask

    task automatic test_full_list();
        int i;
        i = 0;
        while (list_len < LIST_CAP) begin
            if (i % 2) push_op(pss_pkg::OP_SORTED, 6'd0, 32'(i % 4));
            else push_op(pss_pkg::OP_INSERT, 6'($urandom_range(list_len, 0)), 32'(i % 4));
            i++;
        end
        push_op(pss_pkg::OP_INSERT, 6'd32, 32'h9);
        push_op(pss_pkg::OP_INSERT, 6'd33, 32'h9);
        push_op(pss_pkg::OP_SORTED, 6'd0, 32'h0);
        push_op(pss_pkg::OP_SET, 6'd31, 32'hdead_beef);
        push_op(pss_pkg::OP_GET, 6'd31, 32'h0);
        push_op(pss_pkg::OP_GET, 6'd32, 32'h0);
        push_op(pss_pkg::OP_FIND, 6'd0, 32'hdead_beef);
        push_op(pss_pkg::OP_ERASE, 6'd31, 32'h0);
        for (i = 0; i < 4; i++) push_op(pss_pkg::OP_REMOVE, 6'd0, 32'(i));
        wait_drain();
    endtask

    // long hold on the result side so the input stalls
    task automatic test_backpressure();
        int i;
        sink_hold = 300;
        for (i = 0; i < 12; i++)
            push_op(pss_pkg::OP_SORTED, 6'd0, $urandom_range(7, 0));
        wait_drain();
        push_op(pss_pkg::OP_FIND, 6'd0, 32'h3);
        push_op(pss_pkg::OP_REMOVE, 6'd0, 32'h3);
        wait_drain();
    endtask

    task automatic test_random_ops(int n);
        logic [2:0] grow_order [8];
        logic [2:0] op;
        logic [5:0] pos;
        logic [31:0] val;
        int grow_cut [7];
        int shrink_cut [7];
        int sent;
        int burst;
        int r;
        int k;
        bit grow;
        grow_order = '{pss_pkg::OP_INSERT, pss_pkg::OP_SORTED, pss_pkg::OP_ERASE,
                       pss_pkg::OP_REMOVE, pss_pkg::OP_GET, pss_pkg::OP_SET,
                       pss_pkg::OP_FIND, OP_NONE};
        grow_cut   = '{24, 48, 56, 60, 72, 82, 96};
        shrink_cut = '{8, 16, 46, 58, 70, 80, 96};
        sent       = 0;
        sink_quiet = 1'b1;
        while (sent < n) begin
            if (sent >= 120) sink_quiet = 1'b0;
            burst = $urandom_range(16, 1);
            repeat (burst) begin
                grow = ((sent / 96) % 2) == 0;
                r    = $urandom_range(99, 0);
                k    = 0;
                while (k < 7 && r >= (grow ? grow_cut[k] : shrink_cut[k])) k++;
                op = grow_order[k];

                if ($urandom_range(9, 0) == 0)
                    pos = 6'($urandom_range(63, 0));
                else if (op == pss_pkg::OP_INSERT)
                    pos = 6'($urandom_range(list_len, 0));
                else
                    pos = (list_len == 0) ? 6'd0 : 6'($urandom_range(list_len - 1, 0));

                k = $urandom_range(9, 0);
                if (list_len > 0 && k < 4 &&
                    (op == pss_pkg::OP_FIND || op == pss_pkg::OP_REMOVE ||
                     op == pss_pkg::OP_SORTED))
                    val = list_mem[$urandom_range(list_len - 1, 0)];
                else if (k < 6)
                    val = $urandom_range(7, 0);
                else if (k == 6)
                    val = $urandom_range(1, 0) ? 32'hffff_ffff : 32'h8000_0000;
                else
                    val = $urandom;

                push_op(op, pos, val);
                sent++;
            end
            if (sent > 120 && $urandom_range(3, 0) != 0) source_idle($urandom_range(10, 1));
            if ($urandom_range(40, 0) == 0) wait_drain();
        end
        wait_drain();
    endtask

    task automatic finish_run();
        wait_drain();
        repeat (SETTLE) @(posedge i_clk);
        if (expected_results.size() != 0)
            report_mismatch("results never returned", expected_results.size(), 0);
        $display("tb: %0d transactions in, %0d results out, list peak %0d, full flagged %0d times",
                 op_hits.sum(), results_in, peak_len, full_hits);
        $display("tb: per opcode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 op_hits[0], op_hits[1], op_hits[2], op_hits[3],
                 op_hits[4], op_hits[5], op_hits[6], op_hits[7]);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    endtask

    initial begin
        foreach (op_hits[i]) op_hits[i] = 0;
        foreach (list_mem[i]) list_mem[i] = '0;
        apply_reset();
        test_empty_list();
        test_basic_ops();
        test_full_list();
        test_backpressure();
        test_random_ops(900);
        finish_run();
    end

endmodule
